FILE: hw/rtl/mh2_pkg.sv
// Shared constants, datapath operation codes and command types for the MurmurHash2 block.
`default_nettype none

package mh2_pkg;

  localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
  localparam int unsigned MIX_SHIFT   = 24;
  localparam int unsigned FIN_SHIFT_A = 13;
  localparam int unsigned FIN_SHIFT_B = 15;
  localparam logic [2:0]  FULL_BYTES  = 3'd4;

  // One operation of the shared multiplier datapath.
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_KMUL1 = 3'd1,
    OP_KMUL2 = 3'd2,
    OP_HMIX  = 3'd3,
    OP_HPART = 3'd4,
    OP_FIN   = 3'd5,
    OP_OUT   = 3'd6
  } dp_op_t;

  typedef struct packed {
    logic   load;      // capture the accepted beat
    logic   load_len;  // start the running hash from the byte length
    dp_op_t op;
  } dp_cmd_t;

endpackage : mh2_pkg

`default_nettype wire

FILE: hw/rtl/mh2_datapath.sv
// Datapath of the MurmurHash2 block: word, key and hash registers around one shared multiplier.
`default_nettype none

module mh2_datapath
  import mh2_pkg::*;
(
  input  wire logic        clk,
  input  dp_cmd_t          cmd,
  input  wire logic [31:0] in_word,
  input  wire logic [1:0]  in_byte_count,
  input  wire logic [31:0] in_total_length,
  output logic      [31:0] hash_out
);

  logic [31:0] word_r;
  logic [1:0]  cnt_r;
  logic [31:0] k_r;
  logic [31:0] h_r;
  logic [31:0] hash_r;

  logic [31:0] mask;
  logic [31:0] mul_a;
  logic [31:0] prod;

  always_comb begin
    case (cnt_r)
      2'd1:    mask = 32'h0000_00ff;
      2'd2:    mask = 32'h0000_ffff;
      2'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'h0000_0000;
    endcase
  end

  // Operand select for the single multiplier by the mixing constant.
  always_comb begin
    case (cmd.op)
      OP_KMUL1: mul_a = word_r;
      OP_KMUL2: mul_a = k_r ^ (k_r >> MIX_SHIFT);
      OP_HMIX:  mul_a = h_r;
      OP_HPART: mul_a = h_r ^ (word_r & mask);
      OP_FIN:   mul_a = h_r ^ (h_r >> FIN_SHIFT_A);
      default:  mul_a = h_r;
    endcase
  end

  assign prod = mul_a * MIX_MUL;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word_r <= in_word;
      cnt_r  <= in_byte_count;
      if (cmd.load_len) begin
        h_r <= in_total_length;
      end
    end
    case (cmd.op)
      OP_KMUL1, OP_KMUL2: k_r <= prod;
      OP_HMIX:            h_r <= prod ^ k_r;
      OP_HPART, OP_FIN:   h_r <= prod;
      OP_OUT:             hash_r <= h_r ^ (h_r >> FIN_SHIFT_B);
      default: ;
    endcase
  end

  assign hash_out = hash_r;

endmodule : mh2_datapath

`default_nettype wire

FILE: hw/rtl/mh2_ctrl.sv
// Controller of the MurmurHash2 block: sequences the multiply steps and runs both handshakes.
`default_nettype none

module mh2_ctrl
  import mh2_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [2:0] in_byte_count,
  input  wire logic       in_last,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  output dp_cmd_t         cmd
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_KMUL1 = 7'b0000010,
    ST_KMUL2 = 7'b0000100,
    ST_HMIX  = 7'b0001000,
    ST_HPART = 7'b0010000,
    ST_FIN   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;
  logic   in_msg_r, in_msg_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_write;

  assign accept    = (state_r == ST_IDLE) && in_valid;
  assign out_write = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt    = state_r;
    last_nxt     = last_r;
    in_msg_nxt   = in_msg_r;
    cmd.load     = 1'b0;
    cmd.load_len = !in_msg_r;
    cmd.op       = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          last_nxt   = in_last;
          in_msg_nxt = 1'b1;
          if (!in_last || in_byte_count >= FULL_BYTES) begin
            state_nxt = ST_KMUL1;
          end else if (in_byte_count == 3'd0) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_HPART;
          end
        end
      end
      ST_KMUL1: begin
        cmd.op    = OP_KMUL1;
        state_nxt = ST_KMUL2;
      end
      ST_KMUL2: begin
        cmd.op    = OP_KMUL2;
        state_nxt = ST_HMIX;
      end
      ST_HMIX: begin
        cmd.op    = OP_HMIX;
        state_nxt = last_r ? ST_FIN : ST_IDLE;
      end
      ST_HPART: begin
        cmd.op    = OP_HPART;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.op    = OP_FIN;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_write) begin
          cmd.op     = OP_OUT;
          in_msg_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (out_write) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_r      <= 1'b0;
      in_msg_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      in_msg_r    <= in_msg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = !accept && (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule : mh2_ctrl

`default_nettype wire

FILE: hw/rtl/murmur2_hash32.sv
// Top level of the streaming 32-bit MurmurHash2 block (seed 0).
`default_nettype none

// Streaming 32-bit MurmurHash2 with seed 0. A message enters as little-endian
// 32-bit words, one beat per word; the first beat of a message carries the total
// byte length, which seeds the running hash, and the beat with in_last set
// carries 0 to 4 valid low bytes in in_byte_count (values above 4 count as 4).
// Exactly one out_hash beat follows each final input beat; other beats return
// nothing. All multiplications by the mixing constant go through one shared
// 32x32 multiplier with a register after it, so the input stalls while an item
// steps through: a non-final word is accepted, then takes two key multiplies and
// a hash multiply; a final full word adds the finishing multiply and the output
// load; a final partial word takes the tail multiply, then finishing and load; an
// empty message only finishing and load. The output register holds a finished hash
// while the next message is already being accepted and mixed; the block waits
// only if a second hash is ready before the first one has been taken.
module murmur2_hash32
  import mh2_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_word,
  input  wire logic [2:0]  in_byte_count,
  input  wire logic [31:0] in_total_length,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [31:0] out_hash
);

  dp_cmd_t cmd;

  // The controller decides the step sequence from the accepted beat.
  mh2_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_byte_count (in_byte_count),
    .in_last       (in_last),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cmd           (cmd)
  );

  // The datapath holds the word, key and running hash plus the output register.
  // Only the two low count bits reach it: the partial-tail mask needs nothing more.
  mh2_datapath u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .in_word         (in_word),
    .in_byte_count   (in_byte_count[1:0]),
    .in_total_length (in_total_length),
    .hash_out        (out_hash)
  );

  // A non-final beat never produces a result on the next edge.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_last |=> !$rose(out_valid))
    else $error("result appeared right after a non-final beat");

  // Every item has further steps after its accept, so the block is busy after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted on consecutive cycles");

  // A new result is only loaded while the input side was held off.
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result loaded while the block was idle");

endmodule : murmur2_hash32

`default_nettype wire

FILE: dv/tb_murmur2_hash32.sv
// Self-checking testbench for the streaming 32-bit MurmurHash2 block.
module tb_murmur2_hash32;
  timeunit 1ns;
  timeprecision 1ps;

  import mh2_pkg::*;

  // The watchdog fires after this many consecutive cycles without any handshake.
  // The longest quiet stretch of a correct run is a sender gap, the block's work on
  // an item and a result stall, so this leaves a wide margin.
  localparam int unsigned QUIET_LIMIT = 400;
  // Cycles allowed after the last hash for anything stray to show up.
  localparam int unsigned TAIL_WAIT = 20;

  logic        clk;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic [31:0] in_word         = '0;
  logic [2:0]  in_byte_count   = '0;
  logic [31:0] in_total_length = '0;
  logic        in_last         = 1'b0;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  logic [31:0] out_hash;

  murmur2_hash32 DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_word         (in_word),
    .in_byte_count   (in_byte_count),
    .in_total_length (in_total_length),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hash        (out_hash)
  );

  // Hashes predicted for accepted final beats, oldest first.
  logic [31:0] hash_due[$];

  // Predictor state: the hash carried between beats and whether a message is open.
  logic [31:0] run_hash = '0;
  logic        msg_open = 1'b0;
  logic [31:0] h_work;
  logic [2:0]  tail;
  // Oldest prediction, as taken by the result checker.
  logic [31:0] hash_exp;

  // Largest idle draw on each side; zero gives a stretch with no idling at all.
  int unsigned gap_cap_in    = 12;
  int unsigned stall_cap_out = 12;
  int unsigned stall_left    = 0;

  int unsigned errors         = 0;
  int unsigned sent_beats     = 0;
  int unsigned msgs_seen      = 0;
  int unsigned hashes_checked = 0;
  int unsigned quiet_cycles   = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // One body round: multiply the word, fold its top byte down, multiply again,
  // then fold the result into the running hash after scaling that by the constant.
  function automatic logic [31:0] mix_word(input logic [31:0] h, input logic [31:0] w);
    logic [31:0] k;
    k = w * MIX_MUL;
    k = k ^ (k >> MIX_SHIFT);
    k = k * MIX_MUL;
    return (h * MIX_MUL) ^ k;
  endfunction

  // Final avalanche applied once per message.
  function automatic logic [31:0] finalize_hash(input logic [31:0] h);
    logic [31:0] f;
    f = h ^ (h >> FIN_SHIFT_A);
    f = f * MIX_MUL;
    return f ^ (f >> FIN_SHIFT_B);
  endfunction

  // Mostly random words, with the all-zero and all-one patterns mixed in.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(9, 0))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Predictor. Every accepted input beat advances the copy of the block state;
  // a final beat also queues the hash the block owes us. The inputs are driven
  // with nonblocking assignments, so at the edge we see the accepted values.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      // The first beat of a message seeds the hash with the byte length.
      h_work = msg_open ? run_hash : in_total_length;
      if (!in_last) begin
        run_hash = mix_word(h_work, in_word);
        msg_open = 1'b1;
      end else begin
        // Byte counts above four are treated as a full word.
        tail = (in_byte_count > FULL_BYTES) ? FULL_BYTES : in_byte_count;
        if (tail == FULL_BYTES) begin
          h_work = mix_word(h_work, in_word);
        end else if (tail != 3'd0) begin
          // A short tail only xors in its valid low bytes before one multiply.
          h_work = h_work ^ (in_word & ((32'h1 << (8 * tail)) - 32'h1));
          h_work = h_work * MIX_MUL;
        end
        hash_due.push_back(finalize_hash(h_work));
        run_hash = '0;
        msg_open = 1'b0;
        msgs_seen++;
      end
    end
  end

  // Result checker: each accepted hash beat is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (hash_due.size() == 0) begin
        $error("hash: no beat expected, actual %08h", out_hash);
        errors++;
      end else begin
        hash_exp = hash_due.pop_front();
        if (out_hash !== hash_exp) begin
          $error("hash: expected %08h, actual %08h", hash_exp, out_hash);
          errors++;
        end
        hashes_checked++;
      end
    end
  end

  // Result receiver. After each accepted hash it draws how many cycles to stall the
  // next one; the countdown only runs while a hash is actually offered, so the
  // stall really lands on a waiting result.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        stall_left = (stall_cap_out == 0) ? 0 : $urandom_range(stall_cap_out, 0);
        out_stall <= (stall_left != 0);
      end else if (out_valid && stall_left != 0) begin
        stall_left--;
        out_stall <= (stall_left != 0);
      end
    end
  end

  // Watchdog on progress: any handshake on either side clears the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Watchdog: no beat moved for %0d cycles.", quiet_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Sends one input beat. Called right after a rising edge. A gap of zero keeps
  // in_valid high from the previous beat, so valid is never dropped and raised in
  // the same step. Returns at the edge that accepted the beat.
  task automatic send_beat(input logic [31:0] w, input logic [2:0] cnt,
                           input logic [31:0] len, input logic fin);
    int unsigned gap;
    gap = (gap_cap_in == 0) ? 0 : $urandom_range(gap_cap_in, 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_word         <= w;
    in_byte_count   <= cnt;
    in_total_length <= len;
    in_last         <= fin;
    do @(posedge clk); while (in_stall);
    sent_beats++;
  endtask

  // Sends a whole message: full words first, then a final word with the given tail.
  // On the body beats the byte count is random, since the block must not read it.
  task automatic send_message(input int unsigned beats, input logic [2:0] tail_cnt,
                              input logic [31:0] len);
    for (int unsigned i = 1; i < beats; i++) begin
      send_beat(pick_word(), 3'($urandom_range(7, 0)), len, 1'b0);
    end
    send_beat(pick_word(), tail_cnt, len, 1'b1);
  endtask

  // Holds the sender off until every predicted hash has been delivered. The queue
  // is first looked at after the next edge, once the predictor has seen the last beat.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (hash_due.size() != 0);
  endtask

  // Empty messages: the hash is just the finalized length, including the extremes.
  task automatic test_empty_message();
    send_beat(32'h0000_0000, 3'd0, 32'h0000_0000, 1'b1);
    send_beat(32'hffff_ffff, 3'd0, 32'hffff_ffff, 1'b1);
    send_beat($urandom, 3'd0, $urandom, 1'b1);
  endtask

  // Every byte count on a single-beat message, the oversized counts five to seven
  // among them; even counts use all-one words, so that a wrong mask shows at once.
  task automatic test_tail_lengths();
    for (int c = 0; c < 8; c++) begin
      send_beat((c % 2 == 0) ? 32'hffff_ffff : $urandom, 3'(c), 32'(c), 1'b1);
    end
  endtask

  // Fields the block must ignore: the byte count on body beats and the length after
  // the first beat. The second message's stated length also disagrees with the bytes delivered.
  task automatic test_unread_fields();
    send_beat(32'h0403_0201, 3'd7, 32'd10, 1'b0);
    send_beat(32'h0807_0605, 3'd1, 32'hdead_beef, 1'b0);
    send_beat(32'h0000_0a09, 3'd2, 32'h0000_0000, 1'b1);
    send_beat(32'h1234_5678, 3'd0, 32'hffff_ffff, 1'b0);
    send_beat(32'h9abc_def0, 3'd3, 32'd1, 1'b1);
  endtask

  // Multi-word messages built from the extreme word patterns.
  task automatic test_word_extremes();
    send_beat(32'h0000_0000, 3'd4, 32'd8, 1'b0);
    send_beat(32'hffff_ffff, 3'd4, 32'd8, 1'b1);
    send_beat(32'hffff_ffff, 3'd0, 32'd6, 1'b0);
    send_beat(32'h0000_0000, 3'd2, 32'd6, 1'b1);
  endtask

  // Short messages back to back against a slow receiver, so that a second hash is
  // finished while the first still sits in the output register.
  task automatic test_hash_backpressure();
    gap_cap_in    = 0;
    stall_cap_out = 12;
    for (int i = 0; i < 40; i++) begin
      send_message($urandom_range(2, 1), 3'($urandom_range(4, 0)), $urandom);
    end
    // Now the opposite: a receiver that never stalls and a sender with gaps.
    gap_cap_in    = 12;
    stall_cap_out = 0;
    for (int i = 0; i < 10; i++) begin
      send_message($urandom_range(3, 1), 3'($urandom_range(4, 0)), $urandom);
    end
    wait_for_drain();
    stall_cap_out = 12;
  endtask

  // Random traffic, mostly well-formed messages of consistent length, some with a
  // stated length that is wrong, and some loose beats with every field random.
  task automatic test_random_streams(input int unsigned target);
    int unsigned stop_at;
    int unsigned beats;
    int unsigned kind;
    logic [2:0]  tail_cnt;
    bit          paused;
    stop_at = sent_beats + target;
    paused  = 1'b0;
    while (sent_beats < stop_at) begin
      // Now and then switch either side between idling and running flat out.
      if ($urandom_range(9, 0) == 0) gap_cap_in    = (gap_cap_in == 0) ? 12 : 0;
      if ($urandom_range(9, 0) == 0) stall_cap_out = (stall_cap_out == 0) ? 12 : 0;
      // Halfway through, stop sending until the block has delivered everything.
      if (!paused && sent_beats >= stop_at - target / 2) begin
        wait_for_drain();
        paused = 1'b1;
      end
      kind  = $urandom_range(99, 0);
      beats = ($urandom_range(99, 0) < 85) ? $urandom_range(6, 1) : $urandom_range(40, 7);
      if (kind < 75) begin
        tail_cnt = 3'($urandom_range(4, 0));
        send_message(beats, tail_cnt, 32'(4 * (beats - 1) + tail_cnt));
      end else if (kind < 90) begin
        send_message(beats, 3'($urandom_range(7, 0)), $urandom);
      end else begin
        send_beat($urandom, 3'($urandom_range(7, 0)), $urandom, 1'($urandom_range(1, 0)));
      end
    end
    // Close any message a loose beat may have left open.
    send_beat(pick_word(), 3'($urandom_range(4, 0)), $urandom, 1'b1);
  endtask

  initial begin
    // Synchronous reset, held low from the start, then released at an edge.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_message();
    test_tail_lengths();
    test_unread_fields();
    test_word_extremes();
    test_hash_backpressure();
    test_random_streams(1700);

    // All stimulus is in; wait for the outstanding hashes, then a little longer
    // in case the block produces anything it should not.
    wait_for_drain();
    repeat (TAIL_WAIT) @(posedge clk);
    if (hash_due.size() != 0) begin
      $error("hash: %0d predicted beats never arrived", hash_due.size());
      errors++;
    end

    $display("Run covered %0d input beats in %0d messages, all tail sizes and idle patterns;",
             sent_beats, msgs_seen);
    $display("%0d hashes compared, %0d mismatches or stray beats.", hashes_checked, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule : tb_murmur2_hash32

FILE: filelist.f
hw/rtl/mh2_pkg.sv
hw/rtl/mh2_datapath.sv
hw/rtl/mh2_ctrl.sv
hw/rtl/murmur2_hash32.sv
dv/tb_murmur2_hash32.sv
